### rtl/core/dynamic_partition_allocator_macros.svh
// Assertion macros for the partition allocator.
`ifndef DYNAMIC_PARTITION_ALLOCATOR_MACROS_SVH
`define DYNAMIC_PARTITION_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define DPA_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("allocator assertion failed");

// Next-cycle implication.
`define DPA_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("allocator assertion failed");

`endif

### rtl/core/dpa_pkg.sv
// Package: types, codes and constants of the partition allocator.
package dpa_pkg;
   localparam int BLOCK_ENTRIES = 16;
   localparam int HOLE_ENTRIES  = BLOCK_ENTRIES + 1;
   localparam int BIDX_W = $clog2(BLOCK_ENTRIES);
   localparam int HIDX_W = $clog2(HOLE_ENTRIES + 1);
   localparam int BCNT_W = $clog2(BLOCK_ENTRIES + 1);
   localparam int ADDR_W = 16;
   localparam int PADDR_W = 4;
   localparam logic [15:0] TOTAL_RESET = 16'd1024;
   localparam logic [15:0] MIN_RESET   = 16'd10;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_SPACE = 3'd1;
   localparam logic [2:0] ST_NO_PID   = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_RELOC    = 3'd4;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [1:0] REG_TOTAL = 2'd0;
   localparam logic [1:0] REG_FIT   = 2'd1;
   localparam logic [1:0] REG_MIN   = 2'd2;

   typedef struct packed {
      logic        command;
      logic [15:0] alloc_size;
      logic [15:0] target_pid;
   } req_type;

   typedef struct packed {
      logic [15:0] block_pid;
      logic [15:0] start_address;
      logic [15:0] granted_size;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] total_size;
      logic [1:0]  fit_mode;
      logic [15:0] min_remnant;
      logic        clear;
   } cfg_type;

   function automatic rsp_type make_rsp(logic [15:0] pid, logic [15:0] st,
                                        logic [15:0] sz, logic [2:0] code,
                                        logic lst);
      rsp_type r;
      r.block_pid = pid;
      r.start_address = st;
      r.granted_size = sz;
      r.status = code;
      r.last = lst;
      return r;
   endfunction
endpackage

### rtl/core/dynamic_partition_allocator.sv
// Top level: variable-partition allocator with fit search, compaction and free.
//  channel | ports                          | handshake
//  request | start, busy, req_data          | taken when start and not busy
//  result  | rsp_strobe, rsp_data           | one-cycle strobe, no back-pressure
//  config  | psel penable pwrite paddr ...  | APB write, pready tied high
// Allocate: scan the holes, decide, and compact when no single hole is large enough.
// Free: find the block, remove it, return its hole; one hole or block entry per cycle.
// Reset and a total_size write: no blocks, one hole over all memory (none if zero).
// busy also stays high for the cycle after a total_size write.
// Results leave one per cycle from an output register; the receiver cannot stall.
`include "dynamic_partition_allocator_macros.svh"
module dynamic_partition_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  dpa_pkg::req_type            req_data,
   output logic                        rsp_strobe,
   output dpa_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [dpa_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import dpa_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SCAN    = 7'b0000010,
      S_DECIDE  = 7'b0000100,
      S_COMPACT = 7'b0001000,
      S_FSCAN   = 7'b0010000,
      S_FREM    = 7'b0100000,
      S_FPOS    = 7'b1000000
   } state_type;

   cfg_type cfg;

   state_type   state_ff;
   logic [15:0] req_ff, tp_ff, pid_ff;
   logic [HIDX_W-1:0] idx_ff, sel_ff, hcnt_ff;
   logic        sel_ok_ff;
   logic [15:0] sel_size_ff, sel_start_ff, sum_ff, addr_ff;
   logic [BCNT_W-1:0] bj_ff, bcnt_ff;
   logic [BIDX_W-1:0] fk_ff;
   logic [15:0] fs_ff, fl_ff, pv_start_ff, pv_size_ff;
   logic        rsp_strobe_ff;
   rsp_type     rsp_ff;

   logic [15:0] hs_ff [HOLE_ENTRIES];
   logic [15:0] hz_ff [HOLE_ENTRIES];
   logic [15:0] bo_ff [BLOCK_ENTRIES];
   logic [15:0] bs_ff [BLOCK_ENTRIES];
   logic [15:0] bl_ff [BLOCK_ENTRIES];

   logic        accept, first_fit, at_end, scan_hit, stop, m_next, m_prev;
   logic [15:0] cur_hs, cur_hz, rem, pid_nx, pv_end;
   logic [HIDX_W-1:0] pm;
   logic [BCNT_W-1:0] bj_m1;
   logic [BIDX_W-1:0] bk, bw;

   dpa_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .cfg    (cfg)
   );

   assign pready = 1'b1;
   assign busy = (state_ff != S_IDLE) || cfg.clear;
   assign accept = start & ~busy;
   assign first_fit = (cfg.fit_mode != FIT_BEST) && (cfg.fit_mode != FIT_WORST);
   assign at_end = (idx_ff == hcnt_ff);
   assign cur_hs = at_end ? 16'd0 : hs_ff[idx_ff];
   assign cur_hz = at_end ? 16'd0 : hz_ff[idx_ff];
   assign scan_hit = !at_end && (cur_hz >= req_ff);
   assign bj_m1 = bj_ff - BCNT_W'(1);
   assign bk = bj_m1[BIDX_W-1:0];
   assign bw = bcnt_ff[BIDX_W-1:0];
   assign pid_nx = pid_ff + 16'd1;
   assign pm = idx_ff - HIDX_W'(1);
   assign pv_end = pv_start_ff + pv_size_ff;
   assign stop = at_end || !(cur_hs < fs_ff);
   assign m_next = !at_end && ((fs_ff + fl_ff) == cur_hs);
   assign m_prev = (idx_ff != '0) && (pv_end == fs_ff);
   assign rem = (state_ff == S_COMPACT) ? (sum_ff - req_ff) : (sel_size_ff - req_ff);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pid_ff <= 16'd0;
         rsp_strobe_ff <= 1'b0;
         hcnt_ff <= HIDX_W'(1);
         bcnt_ff <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (cfg.clear) begin
            hcnt_ff <= (cfg.total_size != 16'd0) ? HIDX_W'(1) : '0;
            bcnt_ff <= '0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff <= req_data.alloc_size;
                  tp_ff <= req_data.target_pid;
                  idx_ff <= '0;
                  sel_ok_ff <= 1'b0;
                  sum_ff <= 16'd0;
                  bj_ff <= bcnt_ff;
                  if (req_data.command == CMD_FREE) begin
                     state_ff <= S_FSCAN;
                  end else if (req_data.alloc_size == 16'd0) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_ff <= make_rsp(16'd0, 16'd0, 16'd0, ST_NO_SPACE, 1'b1);
                  end else if (bcnt_ff >= BCNT_W'(BLOCK_ENTRIES)) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_ff <= make_rsp(16'd0, 16'd0, 16'd0, ST_FULL, 1'b1);
                  end else begin
                     pid_ff <= pid_nx;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (at_end) begin
                  state_ff <= S_DECIDE;
               end else begin
                  sum_ff <= sum_ff + cur_hz;
                  idx_ff <= idx_ff + HIDX_W'(1);
                  if (scan_hit && (!sel_ok_ff
                        || (cfg.fit_mode == FIT_BEST && cur_hz < sel_size_ff)
                        || (cfg.fit_mode == FIT_WORST && cur_hz > sel_size_ff))) begin
                     sel_ok_ff <= 1'b1;
                     sel_ff <= idx_ff;
                     sel_size_ff <= cur_hz;
                     sel_start_ff <= cur_hs;
                  end
                  if (scan_hit && !sel_ok_ff && first_fit)
                     state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (sel_ok_ff) begin
                  rsp_strobe_ff <= 1'b1;
                  bcnt_ff <= bcnt_ff + BCNT_W'(1);
                  state_ff <= S_IDLE;
                  if (rem != 16'd0 && rem >= cfg.min_remnant) begin
                     rsp_ff <= make_rsp(pid_ff, sel_start_ff, req_ff, ST_OK, 1'b1);
                  end else begin
                     rsp_ff <= make_rsp(pid_ff, sel_start_ff, sel_size_ff, ST_OK, 1'b1);
                     hcnt_ff <= hcnt_ff - HIDX_W'(1);
                  end
               end else if (sum_ff < req_ff) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff <= make_rsp(pid_ff, 16'd0, 16'd0, ST_NO_SPACE, 1'b1);
                  state_ff <= S_IDLE;
               end else begin
                  addr_ff <= 16'd0;
                  state_ff <= S_COMPACT;
               end
            end
            S_COMPACT: begin
               if (bj_ff == '0) begin
                  rsp_strobe_ff <= 1'b1;
                  bcnt_ff <= bcnt_ff + BCNT_W'(1);
                  state_ff <= S_IDLE;
                  if (rem != 16'd0 && rem >= cfg.min_remnant) begin
                     rsp_ff <= make_rsp(pid_ff, addr_ff, req_ff, ST_OK, 1'b1);
                     hcnt_ff <= HIDX_W'(1);
                  end else begin
                     rsp_ff <= make_rsp(pid_ff, addr_ff, sum_ff, ST_OK, 1'b1);
                     hcnt_ff <= '0;
                  end
               end else begin
                  if (bs_ff[bk] != addr_ff) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_ff <= make_rsp(bo_ff[bk], addr_ff, bl_ff[bk], ST_RELOC, 1'b0);
                  end
                  addr_ff <= addr_ff + bl_ff[bk];
                  bj_ff <= bj_m1;
               end
            end
            S_FSCAN: begin
               if (bj_ff == '0) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff <= make_rsp(tp_ff, 16'd0, 16'd0, ST_NO_PID, 1'b1);
                  state_ff <= S_IDLE;
               end else if (bo_ff[bk] == tp_ff) begin
                  fk_ff <= bk;
                  fs_ff <= bs_ff[bk];
                  fl_ff <= bl_ff[bk];
                  state_ff <= S_FREM;
               end else begin
                  bj_ff <= bj_m1;
               end
            end
            S_FREM: begin
               bcnt_ff <= bcnt_ff - BCNT_W'(1);
               pv_start_ff <= 16'd0;
               pv_size_ff <= 16'd0;
               state_ff <= S_FPOS;
            end
            S_FPOS: begin
               if (!stop) begin
                  pv_start_ff <= cur_hs;
                  pv_size_ff <= cur_hz;
                  idx_ff <= idx_ff + HIDX_W'(1);
               end else begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_ff <= make_rsp(tp_ff, fs_ff, fl_ff, ST_OK, 1'b1);
                  state_ff <= S_IDLE;
                  if (m_prev && m_next)
                     hcnt_ff <= hcnt_ff - HIDX_W'(1);
                  else if (!m_prev && !m_next)
                     hcnt_ff <= hcnt_ff + HIDX_W'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // hole table
   always_ff @(posedge clock) begin
      if (reset || cfg.clear) begin
         hs_ff[0] <= 16'd0;
         hz_ff[0] <= reset ? TOTAL_RESET : cfg.total_size;
      end else begin
         case (state_ff)
            S_DECIDE: begin
               if (sel_ok_ff) begin
                  if (rem != 16'd0 && rem >= cfg.min_remnant) begin
                     hs_ff[sel_ff] <= sel_start_ff + req_ff;
                     hz_ff[sel_ff] <= rem;
                  end else begin
                     for (int i = 0; i < HOLE_ENTRIES - 1; i++) begin
                        if (HIDX_W'(i) >= sel_ff) begin
                           hs_ff[i] <= hs_ff[i+1];
                           hz_ff[i] <= hz_ff[i+1];
                        end
                     end
                  end
               end
            end
            S_COMPACT: begin
               if (bj_ff == '0) begin
                  hs_ff[0] <= addr_ff + req_ff;
                  hz_ff[0] <= rem;
               end
            end
            S_FPOS: begin
               if (stop) begin
                  if (m_prev && m_next) begin
                     hz_ff[pm] <= pv_size_ff + fl_ff + cur_hz;
                     for (int i = 0; i < HOLE_ENTRIES - 1; i++) begin
                        if (HIDX_W'(i) >= idx_ff) begin
                           hs_ff[i] <= hs_ff[i+1];
                           hz_ff[i] <= hz_ff[i+1];
                        end
                     end
                  end else if (m_prev) begin
                     hz_ff[pm] <= pv_size_ff + fl_ff;
                  end else if (m_next) begin
                     hs_ff[idx_ff] <= fs_ff;
                     hz_ff[idx_ff] <= cur_hz + fl_ff;
                  end else begin
                     for (int i = 1; i < HOLE_ENTRIES; i++) begin
                        if (HIDX_W'(i) > idx_ff) begin
                           hs_ff[i] <= hs_ff[i-1];
                           hz_ff[i] <= hz_ff[i-1];
                        end
                     end
                     hs_ff[idx_ff] <= fs_ff;
                     hz_ff[idx_ff] <= fl_ff;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // block table
   always_ff @(posedge clock) begin
      case (state_ff)
         S_DECIDE: begin
            if (sel_ok_ff) begin
               bo_ff[bw] <= pid_ff;
               bs_ff[bw] <= sel_start_ff;
               bl_ff[bw] <= (rem != 16'd0 && rem >= cfg.min_remnant) ? req_ff : sel_size_ff;
            end
         end
         S_COMPACT: begin
            if (bj_ff == '0) begin
               bo_ff[bw] <= pid_ff;
               bs_ff[bw] <= addr_ff;
               bl_ff[bw] <= (rem != 16'd0 && rem >= cfg.min_remnant) ? req_ff : sum_ff;
            end else begin
               bs_ff[bk] <= addr_ff;
            end
         end
         S_FREM: begin
            for (int i = 0; i < BLOCK_ENTRIES - 1; i++) begin
               if (BIDX_W'(i) >= fk_ff) begin
                  bo_ff[i] <= bo_ff[i+1];
                  bs_ff[i] <= bs_ff[i+1];
                  bl_ff[i] <= bl_ff[i+1];
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

   `DPA_ASSERT_IMP(a_reloc_not_last, clock, reset, rsp_strobe && !rsp_data.last, rsp_data.status == ST_RELOC)
   `DPA_ASSERT_IMP(a_hole_bound, clock, reset, state_ff == S_IDLE, hcnt_ff <= HIDX_W'(bcnt_ff) + HIDX_W'(1))
   `DPA_ASSERT_NXT(a_accept_progress, clock, reset, accept, busy || rsp_strobe)
endmodule

### rtl/core/dpa_csr.sv
// Configuration registers of the partition allocator.
module dpa_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [dpa_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output dpa_pkg::cfg_type            cfg
);
   import dpa_pkg::*;

   logic [15:0] total_ff;
   logic [1:0]  fit_ff;
   logic [15:0] min_ff;
   logic        clear_ff;
   logic        wr_en;
   logic [1:0]  ridx;

   assign wr_en = psel & penable & pwrite;
   assign ridx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
         fit_ff <= FIT_FIRST;
         min_ff <= MIN_RESET;
         clear_ff <= 1'b0;
      end else begin
         clear_ff <= 1'b0;
         if (wr_en) begin
            case (ridx)
               REG_TOTAL: begin
                  total_ff <= pwdata[15:0];
                  clear_ff <= 1'b1;
               end
               REG_FIT: fit_ff <= pwdata[1:0];
               REG_MIN: min_ff <= pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (ridx)
         REG_TOTAL: prdata = {16'd0, total_ff};
         REG_FIT:   prdata = {30'd0, fit_ff};
         REG_MIN:   prdata = {16'd0, min_ff};
         default:   prdata = 32'd0;
      endcase
   end

   assign cfg.total_size = total_ff;
   assign cfg.fit_mode = fit_ff;
   assign cfg.min_remnant = min_ff;
   assign cfg.clear = clear_ff;
endmodule
